### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/lr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg
// shared widths, register indexes and controller/datapath link types
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_W   = 6;
  localparam int REG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int ERR_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] GRID_DIM_RESET = 7'd64;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [REG_W-1:0]   grid_reg_t;

  typedef struct packed {
    logic load;
    logic step;
  } lr_cmd_t;

  typedef struct packed {
    logic done;
  } lr_status_t;

endpackage

`default_nettype wire

### src/lr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_if
// valid/ready channels for line commands and rasterized pixels
// ----------------------------------------------------------------------------
interface lr_line_if
  import lr_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pixel_if
  import lr_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   inside_res;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, inside_res, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, inside_res, last, output ready);
endinterface

`default_nettype wire

### src/lr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_ctrl
// two-state controller: take a line command, then walk it pixel by pixel
// ----------------------------------------------------------------------------
module lr_ctrl
  import lr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  output logic            pix_valid,
  input  wire logic       pix_ready,
  input  wire lr_status_t status,
  output lr_cmd_t         ctrl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    cmd_ready  = 1'b0;
    pix_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        pix_valid = 1'b1;
        if (pix_ready) begin
          if (status.done) begin
            state_next = ST_IDLE;
          end else begin
            ctrl.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/lr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_dp
// bresenham datapath: current point, deltas, directions and error term
// ----------------------------------------------------------------------------
module lr_dp
  import lr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  wire logic      clk,
  input  wire lr_cmd_t   ctrl,
  output lr_status_t     status,
  input  wire coord_t    start_x,
  input  wire coord_t    start_y,
  input  wire coord_t    end_x,
  input  wire coord_t    end_y,
  input  wire grid_reg_t grid_width,
  input  wire grid_reg_t grid_height,
  output coord_t         pixel_x,
  output coord_t         pixel_y,
  output logic           inside_res
);

  localparam logic [COORD_W:0] COORD_LIM = (COORD_W+1)'(GRID_SIZE);
  localparam coord_t           COORD_MAX = COORD_W'(GRID_SIZE - 1);

  function automatic coord_t clamp(input coord_t v);
    clamp = ({1'b0, v} >= COORD_LIM) ? COORD_MAX : v;
  endfunction

  coord_t x;
  coord_t y;
  coord_t xe;
  coord_t ye;
  coord_t dx;
  coord_t dy;
  logic   sx;
  logic   sy;
  logic signed [ERR_W-1:0] err;

  coord_t cx0, cy0, cx1, cy1;
  logic signed [ERR_W:0] e2;
  logic signed [ERR_W:0] dx_s;
  logic signed [ERR_W:0] dy_s;
  logic signed [ERR_W:0] err_upd;
  logic                  step_x;
  logic                  step_y;

  always_comb begin
    cx0 = clamp(start_x);
    cy0 = clamp(start_y);
    cx1 = clamp(end_x);
    cy1 = clamp(end_y);
    dx_s = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx});
    dy_s = $signed({{(ERR_W+1-COORD_W){1'b0}}, dy});
    e2   = $signed({err, 1'b0});
    step_x = e2 > -dy_s;
    step_y = e2 < dx_s;
    err_upd = $signed({err[ERR_W-1], err});
    if (step_x) begin
      err_upd = err_upd - dy_s;
    end
    if (step_y) begin
      err_upd = err_upd + dx_s;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x   <= cx0;
      y   <= cy0;
      xe  <= cx1;
      ye  <= cy1;
      dx  <= (cx1 > cx0) ? cx1 - cx0 : cx0 - cx1;
      dy  <= (cy1 > cy0) ? cy1 - cy0 : cy0 - cy1;
      sx  <= cx0 < cx1;
      sy  <= cy0 < cy1;
      err <= $signed({{(ERR_W-COORD_W){1'b0}}, (cx1 > cx0) ? cx1 - cx0 : cx0 - cx1})
           - $signed({{(ERR_W-COORD_W){1'b0}}, (cy1 > cy0) ? cy1 - cy0 : cy0 - cy1});
    end else if (ctrl.step) begin
      err <= err_upd[ERR_W-1:0];
      if (step_x) begin
        x <= sx ? x + 1'b1 : x - 1'b1;
      end
      if (step_y) begin
        y <= sy ? y + 1'b1 : y - 1'b1;
      end
    end
  end

  assign status.done = (x == xe) && (y == ye);
  assign pixel_x     = x;
  assign pixel_y     = y;
  assign inside_res  = ({1'b0, x} < grid_width) && ({1'b0, y} < grid_height);

endmodule

`default_nettype wire

### src/line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer
// bresenham line walker, one pixel item per cycle while the receiver is ready, with grid bounds flag
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  cmd       in   start_x, start_y, end_x, end_y
//  pix       out  pixel_x, pixel_y, inside_res, last
//  cfg       in   cfg_we, cfg_index, cfg_data (grid_width, grid_height)
//
//  a line of n pixels (max(|dx|,|dy|)+1, at most GRID_SIZE) is loaded when
//  the command is taken, then output pixel by pixel; the error-term register
//  steps for each pixel taken but the last. a new command is taken only after
//  the last pixel is gone. a stalled pixel holds the walk. reset returns to
//  idle and sets both grid dimensions to 64.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_rasterizer
  import lr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  lr_line_if.sink                   cmd,
  lr_pixel_if.source                pix,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  grid_reg_t  grid_width;
  grid_reg_t  grid_height;
  lr_cmd_t    ctrl;
  lr_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_DIM_RESET;
      grid_height <= GRID_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  lr_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .status      (status),
    .start_x     (cmd.start_x),
    .start_y     (cmd.start_y),
    .end_x       (cmd.end_x),
    .end_y       (cmd.end_y),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .inside_res  (pix.inside_res)
  );

  assign pix.last = status.done;

  // one line in flight: command side and pixel side never open together
  `ASSERT_IMPLIES(a_one_line, clk, rst, cmd.ready, !pix.valid)
  // a taken command produces its first pixel right away
  `ASSERT_NEXT(a_first_pixel, clk, rst, cmd.valid && cmd.ready, pix.valid)
  // after the last pixel the block is ready for the next command
  `ASSERT_NEXT(a_line_end, clk, rst, pix.valid && pix.ready && pix.last, cmd.ready)
  // a non-final pixel is always followed by another
  `ASSERT_NEXT(a_walk_on, clk, rst, pix.valid && pix.ready && !pix.last, pix.valid)

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// line_rasterizer testbench: directed lines through every octant and the
// raster corners, then random lines under a series of grid sizes. every pixel
// item is checked against a bresenham walk in the bench or a typed-in one.
// ----------------------------------------------------------------------------
module tb_top;
  import lr_pkg::*;

  localparam int GRID_SIZE   = 64;
  localparam int IDLE_PCT    = 16;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES  = 7;
  localparam int TAIL_CYCLES = 20;
  localparam int N_DIRECTED  = 22;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   inside_res;
    logic   last;
  } pixel_item_t;

  // a line command plus, for single-pixel lines, the pixel typed in by hand
  typedef struct packed {
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic        typed;
    pixel_item_t px;
  } line_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  grid_reg_t cfg_data;

  lr_line_if  cmd ();
  lr_pixel_if pix ();

  line_rasterizer #(.GRID_SIZE(GRID_SIZE)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  pixel_item_t pixels_due [$];
  line_row_t   line_hints [$];
  grid_reg_t   width_now  = GRID_DIM_RESET;
  grid_reg_t   height_now = GRID_DIM_RESET;
  int          errors = 0;
  int          stall_cycles = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  line_row_t directed_lines [N_DIRECTED] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, '{6'd0,  6'd0,  1'b1, 1'b1}},
    '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, '{6'd63, 6'd63, 1'b1, 1'b1}},
    '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1, '{6'd42, 6'd21, 1'b1, 1'b1}},
    '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, '0},
    '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, '0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, '0},
    '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, '0},
    '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, '0},
    '{6'd63, 6'd0,  6'd0,  6'd0,  1'b0, '0},
    '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0, '0},
    '{6'd0,  6'd63, 6'd0,  6'd0,  1'b0, '0},
    '{6'd10, 6'd10, 6'd40, 6'd20, 1'b0, '0},
    '{6'd10, 6'd10, 6'd20, 6'd40, 1'b0, '0},
    '{6'd40, 6'd20, 6'd10, 6'd10, 1'b0, '0},
    '{6'd20, 6'd40, 6'd10, 6'd10, 1'b0, '0},
    '{6'd10, 6'd40, 6'd40, 6'd30, 1'b0, '0},
    '{6'd40, 6'd30, 6'd10, 6'd40, 1'b0, '0},
    '{6'd10, 6'd40, 6'd20, 6'd10, 1'b0, '0},
    '{6'd20, 6'd10, 6'd10, 6'd40, 1'b0, '0},
    '{6'd21, 6'd42, 6'd42, 6'd21, 1'b0, '0},
    '{6'd5,  6'd5,  6'd6,  6'd6,  1'b0, '0},
    '{6'd5,  6'd5,  6'd6,  6'd5,  1'b0, '0}
  };

  // bresenham walk from start to end, queueing every pixel with its flags
  function automatic void walk_line(input coord_t x0, y0, x1, y1);
    int x, y, xe, ye, dx, dy, step_x, step_y, err, e2, n;
    pixel_item_t px;
    x  = x0;
    y  = y0;
    xe = x1;
    ye = y1;
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    step_x = (x < xe) ? 1 : -1;
    step_y = (y < ye) ? 1 : -1;
    err = dx - dy;
    for (n = 0; n < GRID_SIZE; n++) begin
      px.pixel_x    = coord_t'(x);
      px.pixel_y    = coord_t'(y);
      px.inside_res = (x < int'(width_now)) && (y < int'(height_now));
      px.last       = (x == xe) && (y == ye);
      pixels_due.push_back(px);
      if (px.last) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += step_x;
      end
      if (e2 < dx) begin
        err += dx;
        y += step_y;
      end
    end
  endfunction

  // scoreboard and predictor state, all sampled at the rising edge
  always @(posedge clk) begin : monitor
    pixel_item_t want;
    line_row_t   hint;
    logic        moved;
    if (rst) begin
      width_now    = GRID_DIM_RESET;
      height_now   = GRID_DIM_RESET;
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (pix.valid && pix.ready) begin
        moved = 1'b1;
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel item: x=%0d y=%0d", pix.pixel_x, pix.pixel_y);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (pix.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix.pixel_x);
            errors++;
          end
          if (pix.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix.pixel_y);
            errors++;
          end
          if (pix.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0b, got %0b", want.inside_res, pix.inside_res);
            errors++;
          end
          if (pix.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, pix.last);
            errors++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        moved = 1'b1;
        hint = line_hints.pop_front();
        if (hint.typed) pixels_due.push_back(hint.px);
        else walk_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y);
      end
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_index)
          REG_GRID_WIDTH:  width_now  = cfg_data;
          REG_GRID_HEIGHT: height_now = cfg_data;
          default: ;
        endcase
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // pixel receiver: random back-pressure, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      pix.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // valid stays high across back-to-back items; here only an idle cycle lowers it
  task automatic send_line(input line_row_t row);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      cmd.valid   <= 1'b0;
      cmd.start_x <= coord_t'($urandom);
      cmd.start_y <= coord_t'($urandom);
      cmd.end_x   <= coord_t'($urandom);
      cmd.end_y   <= coord_t'($urandom);
      @(posedge clk);
    end
    line_hints.push_back(row);
    cmd.valid   <= 1'b1;
    cmd.start_x <= row.sx;
    cmd.start_y <= row.sy;
    cmd.end_x   <= row.ex;
    cmd.end_y   <= row.ey;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  function automatic coord_t near(input coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(10)) - 5;
    if (v < 0) v = 0;
    if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
    return coord_t'(v);
  endfunction

  // as many short lines as random ones, plus some points and axis lines
  task automatic random_line();
    line_row_t row;
    int mode;
    row = '0;
    mode = $urandom_range(9);
    row.sx = coord_t'($urandom);
    row.sy = coord_t'($urandom);
    row.ex = coord_t'($urandom);
    row.ey = coord_t'($urandom);
    if (mode >= 4 && mode <= 7) begin
      row.ex = near(row.sx);
      row.ey = near(row.sy);
    end else if (mode == 8) begin
      row.ex = row.sx;
      row.ey = row.sy;
    end else if (mode == 9) begin
      if ($urandom_range(1)) row.ex = row.sx;
      else row.ey = row.sy;
    end
    send_line(row);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(negedge clk);
    while (pixels_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_grid(input grid_reg_t w, input grid_reg_t h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    grid_reg_t w, h;
    int p, i;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_GRID_WIDTH;
    cfg_data    = '0;
    cmd.valid   = 1'b0;
    cmd.start_x = '0;
    cmd.start_y = '0;
    cmd.end_x   = '0;
    cmd.end_y   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) send_line(directed_lines[i]);
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 7'd0;   h = 7'd0;   end
        1: begin w = 7'd127; h = 7'd127; end
        2: begin w = 7'd1;   h = 7'd1;   end
        3: begin w = 7'd37;  h = 7'd50;  end
        4: begin w = 7'd64;  h = 7'd1;   end
        5: begin
          w = grid_reg_t'($urandom_range(64, 1));
          h = grid_reg_t'($urandom_range(64, 1));
        end
        default: begin w = GRID_DIM_RESET; h = GRID_DIM_RESET; end
      endcase
      set_grid(w, h);
      quiet <= (p == 3);
      // long receiver hold while lines keep coming, so the command side stalls
      if (p == 1) hold_req <= ~hold_req;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) wait_drained();
        random_line();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixels_due.size() != 0) begin
      $error("%0d pixel items never arrived", pixels_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lr_pkg.sv
src/lr_if.sv
src/lr_ctrl.sv
src/lr_dp.sv
src/line_rasterizer.sv
test/tb_top.sv
